@@ rtl/core/resource_pool_allocator_fifo_wait_assert.svh @@
// ----------------------------------------------------------------------------
// Resource pool allocator assertion macros
// Shorthand for the concurrent checks that sit at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RESOURCE_POOL_ALLOCATOR_FIFO_WAIT_ASSERT_SVH
`define RESOURCE_POOL_ALLOCATOR_FIFO_WAIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define RPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rpa: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define RPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rpa: next-cycle check failed");

`endif

@@ rtl/core/rpa_pkg.sv @@
// ----------------------------------------------------------------------------
// Resource pool allocator package
// Beat formats, result kinds, operation codes and the control interface
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rpa_pkg;

	localparam int CLIENT_W = 8;
	localparam int COUNT_W  = 4;
	localparam int RIDX_W   = 3;
	localparam int KIND_W   = 3;

	// Operation codes
	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_GRANT    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_QUEUED   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REJECT   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FREE_ERR = 3'd4;

	// Input beat
	typedef struct packed {
		logic                operation;
		logic [CLIENT_W-1:0] client_id;
		logic [COUNT_W-1:0]  count;
		logic [RIDX_W-1:0]   resource_index;
	} req_t;

	// Result beat
	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [CLIENT_W-1:0] granted_client;
		logic [RIDX_W-1:0]   granted_index;
		logic                last;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic load_in;
		logic exec;
		logic grant_step;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
		logic start_grant;
		logic grant_last;
	} dp_status_t;

endpackage

@@ rtl/core/rpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Resource pool allocator controller
// Sequences one item: capture, decide, then one grant per unstalled cycle.
// ----------------------------------------------------------------------------
module rpa_ctrl import rpa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	output ctrl_cmd_t  cmd,
	input  dp_status_t status
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_GRANT
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign req_ready = ready_q;

	// Commands to the datapath; work waits for a free output slot
	always_comb begin
		cmd            = '0;
		cmd.load_in    = req_valid && ready_q;
		cmd.exec       = (state_q == ST_EXEC) && status.out_free;
		cmd.grant_step = (state_q == ST_GRANT) && status.out_free;
	end

	// State and registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid && ready_q) begin
						state_q <= ST_EXEC;
						ready_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					if (status.out_free) begin
						if (status.start_grant) begin
							state_q <= ST_GRANT;
						end else begin
							state_q <= ST_IDLE;
							ready_q <= 1'b1;
						end
					end
				end
				ST_GRANT: begin
					if (status.out_free && status.grant_last) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/rpa_dpath.sv @@
// ----------------------------------------------------------------------------
// Resource pool allocator datapath
// Busy map, free count, wait queue memory, decision logic and result register.
// ----------------------------------------------------------------------------
module rpa_dpath import rpa_pkg::*; #(
	parameter int NUM_RESOURCES = 8,
	parameter int QUEUE_DEPTH   = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  req_t       req_data,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp_data,
	input  ctrl_cmd_t  cmd,
	output dp_status_t status
);

	localparam int IDX_W  = $clog2(NUM_RESOURCES);
	localparam int FREE_W = $clog2(NUM_RESOURCES + 1);
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int WAIT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W  = ((FREE_W > COUNT_W) ? FREE_W : COUNT_W) + 1;
	localparam int RIX_W  = ((IDX_W > RIDX_W) ? IDX_W : RIDX_W) + 1;
	localparam int IDXO_W = (IDX_W > RIDX_W) ? IDX_W : RIDX_W;

	typedef struct packed {
		logic [CLIENT_W-1:0] client;
		logic [COUNT_W-1:0]  count;
	} wait_entry_t;

	// Architectural state
	logic [NUM_RESOURCES-1:0] busy_q;
	logic [FREE_W-1:0]        free_q;
	logic [PTR_W-1:0]         head_q;
	logic [PTR_W-1:0]         tail_q;
	logic [WAIT_W-1:0]        wait_q;
	wait_entry_t              mem_q [QUEUE_DEPTH];
	wait_entry_t              rd_q;

	// Item and grant working registers
	req_t                in_q;
	logic [COUNT_W-1:0]  gnt_left_q;
	logic [CLIENT_W-1:0] gnt_client_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	// Decision outputs
	logic                emit;
	logic                ex_emit;
	logic [KIND_W-1:0]   ex_kind;
	logic [CLIENT_W-1:0] ex_client;
	logic                ex_grant;
	logic [COUNT_W-1:0]  ex_gnt_cnt;
	logic [CLIENT_W-1:0] ex_gnt_client;
	logic                ex_enq;
	logic                ex_deq;
	logic                ex_release;

	// Comparisons
	logic [CMP_W-1:0] count_ext;
	logic [CMP_W-1:0] need_ext;
	logic [CMP_W-1:0] free_ext;
	logic             req_big;
	logic             req_fits;
	logic             head_fits;
	logic             q_empty;
	logic             q_full;
	logic [RIX_W-1:0] rel_wide;
	logic [IDX_W-1:0] rel_idx;
	logic             rel_ok;
	logic [NUM_RESOURCES-1:0] rel_oh;

	// Lowest free resource
	logic [NUM_RESOURCES-1:0] free_vec;
	logic [NUM_RESOURCES-1:0] low_oh;
	logic [IDX_W-1:0]         low_idx;
	logic [IDXO_W-1:0]        low_idx_wide;

	assign count_ext = CMP_W'(in_q.count);
	assign need_ext  = CMP_W'(rd_q.count);
	assign free_ext  = CMP_W'(free_q);
	assign req_big   = count_ext > CMP_W'(NUM_RESOURCES);
	assign req_fits  = count_ext <= free_ext;
	assign head_fits = need_ext <= (free_ext + CMP_W'(1));
	assign q_empty   = (wait_q == '0);
	assign q_full    = (wait_q == WAIT_W'(QUEUE_DEPTH));

	// Release target: out of range or already free is an error
	assign rel_wide = RIX_W'(in_q.resource_index);
	assign rel_idx  = IDX_W'(rel_wide);
	assign rel_oh   = NUM_RESOURCES'(1) << rel_idx;
	assign rel_ok   = (rel_wide < RIX_W'(NUM_RESOURCES)) && busy_q[rel_idx];

	// Isolate the lowest clear bit, then encode it
	assign free_vec = ~busy_q;
	assign low_oh   = free_vec & (~free_vec + NUM_RESOURCES'(1));

	always_comb begin
		low_idx = '0;
		for (int i = 0; i < NUM_RESOURCES; i++) begin
			if (low_oh[i]) begin
				low_idx = low_idx | IDX_W'(i);
			end
		end
	end

	assign low_idx_wide = IDXO_W'(low_idx);

	// Decision for the captured item
	always_comb begin
		ex_emit       = 1'b0;
		ex_kind       = KIND_GRANT;
		ex_client     = in_q.client_id;
		ex_grant      = 1'b0;
		ex_gnt_cnt    = in_q.count;
		ex_gnt_client = in_q.client_id;
		ex_enq        = 1'b0;
		ex_deq        = 1'b0;
		ex_release    = 1'b0;
		if (in_q.operation == OP_REQUEST) begin
			priority if (req_big) begin
				ex_emit = 1'b1;
				ex_kind = KIND_REJECT;
			end else if (req_fits && q_empty) begin
				if (in_q.count == '0) begin
					ex_emit = 1'b1;
					ex_kind = KIND_EMPTY;
				end else begin
					ex_grant = 1'b1;
				end
			end else if (q_full) begin
				ex_emit = 1'b1;
				ex_kind = KIND_REJECT;
			end else begin
				ex_enq  = 1'b1;
				ex_emit = 1'b1;
				ex_kind = KIND_QUEUED;
			end
		end else begin
			if (!rel_ok) begin
				ex_emit   = 1'b1;
				ex_kind   = KIND_FREE_ERR;
				ex_client = '0;
			end else begin
				ex_release = 1'b1;
				// Serve the queue head once if it now fits
				if (!q_empty && head_fits) begin
					ex_deq        = 1'b1;
					ex_client     = rd_q.client;
					ex_gnt_cnt    = rd_q.count;
					ex_gnt_client = rd_q.client;
					if (rd_q.count == '0) begin
						ex_emit = 1'b1;
						ex_kind = KIND_EMPTY;
					end else begin
						ex_grant = 1'b1;
					end
				end
			end
		end
	end

	assign emit = (cmd.exec && ex_emit) || cmd.grant_step;

	always_comb begin
		status             = '0;
		status.out_free    = !rsp_valid_q || rsp_ready;
		status.start_grant = ex_grant;
		status.grant_last  = (gnt_left_q == COUNT_W'(1));
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= '0;
			free_q      <= FREE_W'(NUM_RESOURCES);
			head_q      <= '0;
			tail_q      <= '0;
			wait_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.exec && ex_release) begin
				busy_q <= busy_q & ~rel_oh;
				free_q <= free_q + FREE_W'(1);
			end else if (cmd.grant_step) begin
				busy_q <= busy_q | low_oh;
				free_q <= free_q - FREE_W'(1);
			end
			if (cmd.exec && ex_enq) begin
				tail_q <= (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
				wait_q <= wait_q + WAIT_W'(1);
			end else if (cmd.exec && ex_deq) begin
				head_q <= (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
				wait_q <= wait_q - WAIT_W'(1);
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Wait queue memory: write at tail, registered read at head
	always_ff @(posedge clk) begin
		if (cmd.exec && ex_enq) begin
			mem_q[tail_q] <= '{client: in_q.client_id, count: in_q.count};
		end
		rd_q <= mem_q[head_q];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= req_data;
		end
		if (cmd.exec && ex_grant) begin
			gnt_left_q   <= ex_gnt_cnt;
			gnt_client_q <= ex_gnt_client;
		end else if (cmd.grant_step) begin
			gnt_left_q <= gnt_left_q - COUNT_W'(1);
		end
		if (cmd.grant_step) begin
			rsp_q.kind           <= KIND_GRANT;
			rsp_q.granted_client <= gnt_client_q;
			rsp_q.granted_index  <= low_idx_wide[RIDX_W-1:0];
			rsp_q.last           <= status.grant_last;
		end else if (cmd.exec && ex_emit) begin
			rsp_q.kind           <= ex_kind;
			rsp_q.granted_client <= ex_client;
			rsp_q.granted_index  <= '0;
			rsp_q.last           <= 1'b1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

@@ rtl/core/resource_pool_allocator_fifo_wait.sv @@
// ----------------------------------------------------------------------------
// Resource pool allocator with FIFO wait queue
// Counting allocator over a pool of identical resources, top level.
// ----------------------------------------------------------------------------
// Usage: req carries a request (client, count) or the release of one index;
// rsp returns results, with last set on the final result of each item.
// A request that fits and finds the queue empty is granted the lowest free
// indices, one result beat per cycle unless stalled; else queued or rejected.
// A release frees one index and serves the queue head once if it now fits.
// A request beat is captured in the input register, decided in the exec state
// and its single result or grant count registered; grants then come from the
// grant state. Items are handled one at a time; the grant run is paced by
// the single lowest-free search over the busy map, which grants one index per
// cycle while the result register is free. req_ready drops for the item's
// whole run and rises once the item's decision and any grants are done.
// Reset empties the queue and frees every resource; no clearing pass is run.
// When the receiver stalls, the result register holds its beat and the
// controller waits; the next request is still taken while a beat is waiting.
// ----------------------------------------------------------------------------
`include "resource_pool_allocator_fifo_wait_assert.svh"

module resource_pool_allocator_fifo_wait import rpa_pkg::*; #(
	parameter int NUM_RESOURCES = 8,
	parameter int QUEUE_DEPTH   = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Controller
	rpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (cmd),
		.status    (status)
	);

	// Datapath
	rpa_dpath #(
		.NUM_RESOURCES (NUM_RESOURCES),
		.QUEUE_DEPTH   (QUEUE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cmd       (cmd),
		.status    (status)
	);

	// Checks
	`RPA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)
	`RPA_ASSERT_NOW(a_single_result_last, clk, arst_n, rsp_valid && (rsp_data.kind != KIND_GRANT), rsp_data.last)
	`RPA_ASSERT_NOW(a_free_err_no_client, clk, arst_n, rsp_valid && (rsp_data.kind == KIND_FREE_ERR), (rsp_data.granted_client == '0) && (rsp_data.granted_index == '0))
	`RPA_ASSERT_NOW(a_no_accept_mid_item, clk, arst_n, cmd.exec || cmd.grant_step, !req_ready)

endmodule

@@ sim/tb_resource_pool_allocator_fifo_wait.sv @@
// ----------------------------------------------------------------------------
// Resource pool allocator testbench
// Drives request and release beats through a valid/ready driver and checks
// every result beat against a cycle-free allocation predictor: lowest-free
// grants, FIFO wait queue, rejects and releases of free indices. Random gaps
// on both sides, a long receiver hold-off and pauses until the pipe drains.
// ----------------------------------------------------------------------------
module tb_resource_pool_allocator_fifo_wait;
	import rpa_pkg::*;

	localparam int POOL_SIZE     = 8;
	localparam int WAIT_DEPTH    = 16;
	localparam int RANDOM_BEATS  = 470;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SHOW_LIMIT    = 10;

	typedef enum logic [1:0] {ACT_BEAT, ACT_DRAIN, ACT_HOLD} act_e;

	typedef struct {
		act_e act;
		req_t beat;
	} plan_t;

	typedef struct {
		logic [CLIENT_W-1:0] client;
		logic [COUNT_W-1:0]  need;
	} waiter_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_data;

	// stimulus plan and expected result beats
	plan_t   plan_q[$];
	rsp_t    due_results[$];

	// allocator shadow state
	logic [POOL_SIZE-1:0] busy_shadow = '0;
	int                   free_shadow = POOL_SIZE;
	waiter_t              waiters[$];

	int   cycle_count = 0;
	int   mismatches = 0;
	logic req_took = 1'b0;
	int   gap_left = 0;
	bit   draining = 1'b0;
	int   hold_asks = 0;
	int   hold_seen = 0;
	int   hold_left = 0;
	int   stall_left = 0;

	resource_pool_allocator_fifo_wait u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// spells with no idling on either side
	function automatic bit quiet_spell();
		return ((cycle_count / 320) % 4) == 2;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet_spell() || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic rsp_t make_rsp(logic [KIND_W-1:0] k, logic [CLIENT_W-1:0] c,
			logic [RIDX_W-1:0] idx, logic fin);
		rsp_t r;
		r.kind           = k;
		r.granted_client = c;
		r.granted_index  = idx;
		r.last           = fin;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	// hand out n lowest free indices, one beat each
	task automatic grant_lowest(logic [CLIENT_W-1:0] who, int n);
		int idx;
		if (n == 0) begin
			due_results.push_back(make_rsp(KIND_EMPTY, who, '0, 1'b1));
		end else begin
			for (int k = 0; k < n; k++) begin
				idx = 0;
				while (idx < POOL_SIZE && busy_shadow[idx])
					idx++;
				busy_shadow[idx] = 1'b1;
				free_shadow--;
				due_results.push_back(make_rsp(KIND_GRANT, who, idx[RIDX_W-1:0],
					k == n - 1));
			end
		end
	endtask

	task automatic allocate_or_release(req_t b);
		waiter_t w;
		if (b.operation == OP_REQUEST) begin
			if (int'(b.count) > POOL_SIZE) begin
				due_results.push_back(make_rsp(KIND_REJECT, b.client_id, '0, 1'b1));
			end else if (int'(b.count) <= free_shadow && waiters.size() == 0) begin
				grant_lowest(b.client_id, int'(b.count));
			end else if (waiters.size() >= WAIT_DEPTH) begin
				due_results.push_back(make_rsp(KIND_REJECT, b.client_id, '0, 1'b1));
			end else begin
				w.client = b.client_id;
				w.need   = b.count;
				waiters.push_back(w);
				due_results.push_back(make_rsp(KIND_QUEUED, b.client_id, '0, 1'b1));
			end
		end else if (!busy_shadow[b.resource_index]) begin
			due_results.push_back(make_rsp(KIND_FREE_ERR, '0, '0, 1'b1));
		end else begin
			busy_shadow[b.resource_index] = 1'b0;
			free_shadow++;
			// only the head is tried, once
			if (waiters.size() != 0 && int'(waiters[0].need) <= free_shadow) begin
				w = waiters.pop_front();
				grant_lowest(w.client, int'(w.need));
			end
		end
	endtask

	task automatic log_mismatch(string what, rsp_t e, rsp_t a);
		mismatches++;
		if (mismatches <= SHOW_LIMIT)
			$display("[%0d] %s: exp kind %0d client %02h idx %0d last %0b, got kind %0d client %02h idx %0d last %0b",
				cycle_count, what, e.kind, e.granted_client, e.granted_index, e.last,
				a.kind, a.granted_client, a.granted_index, a.last);
	endtask

	// ------------------------------------------------------------------------
	// Monitor: predict on accepted request beats, check result beats
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : mon_blk
		rsp_t exp_b;
		req_took <= arst_n && req_valid && req_ready;
		if (arst_n) begin
			if (req_valid && req_ready)
				allocate_or_release(req_data);
			if (rsp_valid && rsp_ready) begin
				if (due_results.size() == 0) begin
					log_mismatch("unexpected beat", '0, rsp_data);
				end else begin
					exp_b = due_results.pop_front();
					if (rsp_data.kind !== exp_b.kind ||
							rsp_data.granted_client !== exp_b.granted_client ||
							rsp_data.granted_index !== exp_b.granted_index ||
							rsp_data.last !== exp_b.last)
						log_mismatch("field mismatch", exp_b, rsp_data);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Driver: request side, fed from the plan queue
	// ------------------------------------------------------------------------
	always @(negedge clk) begin : drv_blk
		plan_t nx;
		logic  v_n;
		req_t  d_n;
		v_n = req_valid;
		d_n = req_data;
		if (arst_n) begin
			if (req_valid && req_took)
				v_n = 1'b0;
			if (!v_n) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (draining) begin
					if (due_results.size() == 0)
						draining = 1'b0;
				end else if (plan_q.size() != 0) begin
					nx = plan_q.pop_front();
					case (nx.act)
						ACT_BEAT: begin
							v_n = 1'b1;
							d_n = nx.beat;
							gap_left = pick_gap();
						end
						ACT_DRAIN: draining = 1'b1;
						ACT_HOLD: hold_asks++;
						default: ;
					endcase
				end
			end
		end
		req_valid <= v_n;
		req_data  <= d_n;
	end

	// ------------------------------------------------------------------------
	// Receiver: result side back-pressure
	// ------------------------------------------------------------------------
	always @(negedge clk) begin : rcv_blk
		logic r_n;
		int   roll;
		r_n = 1'b0;
		if (arst_n) begin
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end else if (hold_left > 0) begin
				hold_left--;
			end else if (stall_left > 0) begin
				stall_left--;
			end else begin
				r_n = 1'b1;
				roll = $urandom_range(0, 99);
				if (!quiet_spell()) begin
					if (roll < 25)
						stall_left = $urandom_range(1, 3);
					else if (roll < 29)
						stall_left = $urandom_range(15, 60);
				end
			end
		end
		rsp_ready <= r_n;
	end

	// run length guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus plan
	// ------------------------------------------------------------------------
	task automatic plan_request(logic [CLIENT_W-1:0] c, logic [COUNT_W-1:0] n);
		plan_t p;
		p.act                 = ACT_BEAT;
		p.beat.operation      = OP_REQUEST;
		p.beat.client_id      = c;
		p.beat.count          = n;
		p.beat.resource_index = RIDX_W'($urandom_range(0, 7));
		plan_q.push_back(p);
	endtask

	task automatic plan_release(logic [RIDX_W-1:0] idx);
		plan_t p;
		p.act                 = ACT_BEAT;
		p.beat.operation      = OP_RELEASE;
		p.beat.client_id      = CLIENT_W'($urandom_range(0, 255));
		p.beat.count          = COUNT_W'($urandom_range(0, 15));
		p.beat.resource_index = idx;
		plan_q.push_back(p);
	endtask

	task automatic plan_marker(act_e a);
		plan_t p;
		p.act  = a;
		p.beat = '0;
		plan_q.push_back(p);
	endtask

	// mostly small counts so the queue keeps moving; a few beyond the pool
	function automatic logic [COUNT_W-1:0] random_count();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 6)
			return COUNT_W'($urandom_range(POOL_SIZE + 1, 15));
		if (roll < 14)
			return '0;
		if (roll < 80)
			return COUNT_W'($urandom_range(1, 4));
		return COUNT_W'($urandom_range(5, POOL_SIZE));
	endfunction

	initial begin : main_blk
		int planned;
		int len;
		int roll;

		// directed beats
		plan_request(8'hFF, 4'd0);         // zero count, empty grant
		plan_request(8'h00, 4'd15);        // far beyond the pool
		plan_request(8'h5A, 4'd9);         // just beyond the pool
		plan_request(8'hA5, 4'd8);         // whole pool, indices 0..7
		plan_request(8'h11, 4'd0);         // zero count fits a full pool
		plan_release(3'd3);                // free with nobody waiting
		plan_release(3'd3);                // release of a free index
		plan_request(8'h22, 4'd2);         // does not fit, queued
		plan_request(8'h33, 4'd0);         // queued behind a waiter
		plan_request(8'h44, 4'd1);
		plan_release(3'd5);                // head now fits
		plan_release(3'd7);                // zero-count head served
		plan_release(3'd6);
		plan_release(3'd0);
		plan_release(3'd0);
		plan_marker(ACT_DRAIN);

		// long receiver hold-off while a burst fills and overflows the queue
		plan_marker(ACT_HOLD);
		plan_request(CLIENT_W'($urandom_range(0, 255)), 4'd8);
		for (int k = 0; k < 20; k++)
			plan_request(CLIENT_W'($urandom_range(0, 255)),
				COUNT_W'($urandom_range(1, POOL_SIZE)));
		planned = 21;

		// random episodes
		while (planned < RANDOM_BEATS) begin
			roll = $urandom_range(0, 99);
			if (roll < 60) begin
				len = $urandom_range(10, 30);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 1))
						plan_request(CLIENT_W'($urandom_range(0, 255)), random_count());
					else
						plan_release(RIDX_W'($urandom_range(0, POOL_SIZE - 1)));
				end
			end else if (roll < 75) begin
				len = $urandom_range(18, 22);
				for (int k = 0; k < len; k++)
					plan_request(CLIENT_W'($urandom_range(0, 255)), random_count());
			end else if (roll < 92) begin
				len = $urandom_range(12, 24);
				for (int k = 0; k < len; k++)
					plan_release(RIDX_W'($urandom_range(0, POOL_SIZE - 1)));
			end else begin
				len = 0;
				plan_marker($urandom_range(0, 2) != 0 ? ACT_DRAIN : ACT_HOLD);
			end
			planned += len;
		end

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		while (plan_q.size() != 0 || req_valid || draining)
			@(negedge clk);
		while (due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		while (due_results.size() != 0)
			log_mismatch("missing beat", due_results.pop_front(), '0);

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
